// ===== rtl/core/m4i_pkg.sv =====
`timescale 1ns / 1ps

package m4i_pkg;

  // Element format: signed fixed point
  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int W      = WORD_WIDTH;
  localparam int B_W    = W + 4;          // second multiplier operand
  localparam int PROD_W = W + B_W;        // product width
  localparam int MIN_W  = 2 * W + 1;      // 2x2 minor
  localparam int COF_W  = 3 * W + 3;      // 3x3 cofactor
  localparam int ACC_W  = 4 * W + 8;      // accumulator and determinant
  localparam int NUM_W  = COF_W + 2 * FRAC_BITS;
  localparam int DSH_W  = ACC_W + W;
  localparam int CMP_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int CNT_W  = $clog2(W + 1);

  localparam int unsigned N_ELEM = 16;
  localparam int unsigned POS_W  = 4;

  typedef enum logic [1:0] {
    BSEL_ELEM,
    BSEL_MINOR,
    BSEL_COF
  } bsel_e;

  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [POS_W-1:0] rd_addr_a;
    logic [POS_W-1:0] rd_addr_b;
    bsel_e            bsel;
    logic [1:0]       minor_idx;
    logic [POS_W-1:0] cof_idx;
    logic [1:0]       chunk;
    logic             mul_en;
    logic             acc_en;
    logic             acc_clr;
    logic             acc_sub;
    logic             store_minor;
    logic             store_cof;
    logic             store_det;
    logic             div_load;
    logic             div_step;
    logic             emit;
    logic [POS_W-1:0] emit_pos;
    logic             emit_last;
  } m4i_cmd_t;

endpackage

// ===== rtl/core/matrix4_inverse.sv =====
`timescale 1ns / 1ps
// 4x4 matrix inverse by cofactors, signed fixed point, one word per cycle in
// while loading. Loading takes 16 accepted words; the run then computes 204
// products on the shared multiplier and each result on the bit-serial divider,
// and no new matrix is accepted until all 16 results have been issued.
// Reset (rst_ni low, asynchronous) returns to loading at position zero.

module matrix4_inverse import m4i_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [W-1:0]  matrix_element_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [W-1:0]  inverse_element_o,
  output logic [POS_W-1:0]     element_position_o,
  output logic                 last_element_o,
  output logic                 singular_o
);

  m4i_cmd_t cmd;
  logic     out_free;

  m4i_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .out_free_i(out_free),
    .cmd_o     (cmd)
  );

  m4i_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .matrix_element_i  (matrix_element_i),
    .out_free_o        (out_free),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .inverse_element_o (inverse_element_o),
    .element_position_o(element_position_o),
    .last_element_o    (last_element_o),
    .singular_o        (singular_o)
  );

endmodule

// ===== rtl/core/m4i_ram.sv =====
`timescale 1ns / 1ps

module m4i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic [WIDTH-1:0]         rd_data_a_o,
  output logic [WIDTH-1:0]         rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

// ===== rtl/core/m4i_ctrl.sv =====
`timescale 1ns / 1ps

module m4i_ctrl import m4i_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_free_i,
  output m4i_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MINOR,
    ST_COFT,
    ST_DET,
    ST_DLOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [1:0]       phase_q;
  logic [POS_W-1:0] pos_q;
  logic [1:0]       k_q;
  logic [1:0]       j_q;
  logic [CNT_W-1:0] cnt_q;

  logic [1:0] dr, dc, col_x, col_y;
  logic       step_done;
  logic       accept;

  // Index of the n-th kept row or column when index d is struck out
  function automatic logic [1:0] skip(input logic [1:0] n, input logic [1:0] d);
    skip = (n >= d) ? n + 2'd1 : n;
  endfunction

  function automatic logic [POS_W-1:0] el_addr(input logic [1:0] r, input logic [1:0] c,
                                               input logic [1:0] row_x, input logic [1:0] col_x_i);
    el_addr = {skip(c, col_x_i), skip(r, row_x)};
  endfunction

  assign dr         = pos_q[3:2];
  assign dc         = pos_q[1:0];
  assign col_x      = (k_q == 2'd0) ? 2'd1 : 2'd0;
  assign col_y      = (k_q == 2'd2) ? 2'd1 : 2'd2;
  assign step_done  = (phase_q == 2'd2);
  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.bsel      = BSEL_ELEM;
    cmd_o.wr_en     = accept;
    cmd_o.wr_addr   = pos_q;
    cmd_o.minor_idx = k_q;
    cmd_o.chunk     = j_q;
    cmd_o.cof_idx   = pos_q;
    cmd_o.emit_pos  = pos_q;
    cmd_o.emit_last = (pos_q == 4'd15);
    case (state_q)
      ST_MINOR: begin
        cmd_o.rd_addr_a   = (j_q == 2'd0) ? el_addr(2'd1, col_x, dr, dc)
                                          : el_addr(2'd1, col_y, dr, dc);
        cmd_o.rd_addr_b   = (j_q == 2'd0) ? el_addr(2'd2, col_y, dr, dc)
                                          : el_addr(2'd2, col_x, dr, dc);
        cmd_o.bsel        = BSEL_ELEM;
        cmd_o.chunk       = 2'd0;
        cmd_o.mul_en      = (phase_q == 2'd1);
        cmd_o.acc_en      = step_done;
        cmd_o.acc_clr     = (j_q == 2'd0);
        cmd_o.acc_sub     = (j_q == 2'd1);
        cmd_o.store_minor = step_done && (j_q == 2'd1);
      end
      ST_COFT: begin
        cmd_o.rd_addr_a = el_addr(2'd0, k_q, dr, dc);
        cmd_o.bsel      = BSEL_MINOR;
        cmd_o.mul_en    = (phase_q == 2'd1);
        cmd_o.acc_en    = step_done;
        cmd_o.acc_clr   = (k_q == 2'd0) && (j_q == 2'd0);
        // fold the checkerboard sign into the middle term's sign
        cmd_o.acc_sub   = (k_q == 2'd1) ^ dr[0] ^ dc[0];
        cmd_o.store_cof = step_done && (k_q == 2'd2) && (j_q == 2'd1);
      end
      ST_DET: begin
        cmd_o.rd_addr_a = {2'b00, pos_q[1:0]};
        cmd_o.bsel      = BSEL_COF;
        cmd_o.cof_idx   = {pos_q[1:0], 2'b00};
        cmd_o.mul_en    = (phase_q == 2'd1);
        cmd_o.acc_en    = step_done;
        cmd_o.acc_clr   = (pos_q[1:0] == 2'd0) && (j_q == 2'd0);
        cmd_o.store_det = step_done && (pos_q[1:0] == 2'd3) && (j_q == 2'd2);
      end
      ST_DLOAD: cmd_o.div_load = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_EMIT:  cmd_o.emit     = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      phase_q <= 2'd0;
      pos_q   <= '0;
      k_q     <= 2'd0;
      j_q     <= 2'd0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (pos_q == 4'd15) begin
              pos_q   <= '0;
              k_q     <= 2'd0;
              j_q     <= 2'd0;
              phase_q <= 2'd0;
              state_q <= ST_MINOR;
            end else begin
              pos_q <= pos_q + 4'd1;
            end
          end
        end
        ST_MINOR, ST_COFT: begin
          if (!step_done) begin
            phase_q <= phase_q + 2'd1;
          end else begin
            phase_q <= 2'd0;
            if (j_q == 2'd0) begin
              j_q <= 2'd1;
            end else begin
              j_q <= 2'd0;
              if (k_q != 2'd2) begin
                k_q <= k_q + 2'd1;
              end else begin
                k_q <= 2'd0;
                if (state_q == ST_MINOR) begin
                  state_q <= ST_COFT;
                end else if (pos_q == 4'd15) begin
                  pos_q   <= '0;
                  state_q <= ST_DET;
                end else begin
                  pos_q   <= pos_q + 4'd1;
                  state_q <= ST_MINOR;
                end
              end
            end
          end
        end
        ST_DET: begin
          if (!step_done) begin
            phase_q <= phase_q + 2'd1;
          end else begin
            phase_q <= 2'd0;
            if (j_q != 2'd2) begin
              j_q <= j_q + 2'd1;
            end else begin
              j_q <= 2'd0;
              if (pos_q[1:0] == 2'd3) begin
                pos_q   <= '0;
                state_q <= ST_DLOAD;
              end else begin
                pos_q <= pos_q + 4'd1;
              end
            end
          end
        end
        ST_DLOAD: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(W)) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free_i) begin
            if (pos_q == 4'd15) begin
              pos_q   <= '0;
              state_q <= ST_LOAD;
            end else begin
              pos_q   <= pos_q + 4'd1;
              state_q <= ST_DLOAD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> out_free_i)
    else $error("result issued while output register busy");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pos_q == 4'd15) |=> (state_q == ST_MINOR))
    else $error("sixteenth word did not start the inversion");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CNT_W'(W)) |=> (state_q == ST_EMIT))
    else $error("divider did not hand over after its last step");

endmodule

// ===== rtl/core/m4i_datapath.sv =====
`timescale 1ns / 1ps

module m4i_datapath import m4i_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  m4i_cmd_t               cmd_i,
  input  logic signed [W-1:0]    matrix_element_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [W-1:0]    inverse_element_o,
  output logic [POS_W-1:0]       element_position_o,
  output logic                   last_element_o,
  output logic                   singular_o
);

  logic [W-1:0] rd_a, rd_b;

  m4i_ram #(
    .WIDTH(W),
    .DEPTH(N_ELEM)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (cmd_i.wr_en),
    .wr_addr_i  (cmd_i.wr_addr),
    .wr_data_i  (matrix_element_i),
    .rd_addr_a_i(cmd_i.rd_addr_a),
    .rd_addr_b_i(cmd_i.rd_addr_b),
    .rd_data_a_o(rd_a),
    .rd_data_b_o(rd_b)
  );

  logic [MIN_W-1:0]  minor_q [3];
  logic [COF_W-1:0]  cof_q   [N_ELEM];
  logic [ACC_W-1:0]  acc_q, det_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]  rem_q;
  logic [DSH_W-1:0]  dsh_q;
  logic [W:0]        quo_q;
  logic              neg_q;

  logic [MIN_W-1:0]  minor_sel;
  logic [COF_W-1:0]  cof_rd, cof_mag;
  logic [ACC_W-1:0]  det_mag;
  logic signed [B_W-1:0] b_op;
  logic [ACC_W-1:0]  prod_ext, term, acc_base, acc_next;
  logic [CMP_W-1:0]  rem_ext, dsh_ext, diff;
  logic              ge, sing, big;
  logic [W-1:0]      lo, result, lim;

  always_comb begin
    case (cmd_i.minor_idx)
      2'd0:    minor_sel = minor_q[0];
      2'd1:    minor_sel = minor_q[1];
      default: minor_sel = minor_q[2];
    endcase
  end

  assign cof_rd = cof_q[cmd_i.cof_idx];

  // second operand: element, or one chunk of a wide minor or cofactor
  always_comb begin
    case (cmd_i.bsel)
      BSEL_MINOR: begin
        if (cmd_i.chunk == 2'd0) b_op = {4'b0000, minor_sel[W-1:0]};
        else                     b_op = {{3{minor_sel[2*W]}}, minor_sel[2*W:W]};
      end
      BSEL_COF: begin
        case (cmd_i.chunk)
          2'd0:    b_op = {4'b0000, cof_rd[W-1:0]};
          2'd1:    b_op = {4'b0000, cof_rd[2*W-1:W]};
          default: b_op = {cof_rd[3*W+2], cof_rd[3*W+2:2*W]};
        endcase
      end
      default: b_op = {{4{rd_b[W-1]}}, rd_b};
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (cmd_i.chunk)
      2'd0:    term = prod_ext;
      2'd1:    term = prod_ext << W;
      default: term = prod_ext << (2 * W);
    endcase
  end

  assign acc_base = cmd_i.acc_clr ? '0 : acc_q;
  assign acc_next = cmd_i.acc_sub ? acc_base - term : acc_base + term;

  assign cof_mag = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : cof_rd;
  assign det_mag = det_q[ACC_W-1] ? ACC_W'(-det_q) : det_q;

  // restoring division, one quotient bit per step, from bit W down
  assign rem_ext = CMP_W'(rem_q);
  assign dsh_ext = CMP_W'(dsh_q);
  assign ge      = (rem_ext >= dsh_ext);
  assign diff    = rem_ext - dsh_ext;

  assign sing = (det_q == '0);
  assign big  = quo_q[W];
  assign lo   = quo_q[W-1:0];
  assign lim  = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    if (sing) begin
      result = '0;
    end else if (neg_q) begin
      result = (big || (lo > lim)) ? lim : W'(-lo);
    end else begin
      result = (big || lo[W-1]) ? ~lim : lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= $signed(rd_a) * b_op;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_next;
    end
    if (cmd_i.store_minor) begin
      case (cmd_i.minor_idx)
        2'd0:    minor_q[0] <= acc_next[MIN_W-1:0];
        2'd1:    minor_q[1] <= acc_next[MIN_W-1:0];
        default: minor_q[2] <= acc_next[MIN_W-1:0];
      endcase
    end
    if (cmd_i.store_cof) begin
      cof_q[cmd_i.cof_idx] <= acc_next[COF_W-1:0];
    end
    if (cmd_i.store_det) begin
      det_q <= acc_next;
    end
    if (cmd_i.div_load) begin
      rem_q <= {cof_mag, {(2*FRAC_BITS){1'b0}}};
      dsh_q <= {det_mag, {W{1'b0}}};
      quo_q <= '0;
      neg_q <= cof_rd[COF_W-1] ^ det_q[ACC_W-1];
    end else if (cmd_i.div_step) begin
      if (ge) rem_q <= diff[NUM_W-1:0];
      quo_q <= {quo_q[W-1:0], ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.emit) begin
      inverse_element_o  <= result;
      element_position_o <= cmd_i.emit_pos;
      last_element_o     <= cmd_i.emit_last;
      singular_o         <= sing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign out_free_o = !out_valid_o || out_ready_i;

endmodule
